// ===== src/cwd_pkg.sv =====
`timescale 1ns / 1ps

package cwd_pkg;

	// window and codeword geometry
	localparam int WIN_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 16;
	localparam int INDEX_BITS  = 12;
	localparam int PREFIX_W    = CODE_W - INDEX_BITS;
	localparam logic [PREFIX_W-1:0] CODE_PREFIX = 4'b1110;
	localparam int BITMAP_DEPTH = 1 << INDEX_BITS;
	localparam int OFFSET_W    = 3;

	// shifts searched for a codeword and for the target message
	localparam int SEARCH_OFFSETS = 8;
	localparam int TARGET_SHIFTS  = WIN_W - CODE_W + 1;

	// the prefix cannot match at two shifts closer than its own length,
	// so each group of PREFIX_W shifts holds at most one candidate
	localparam int GROUP_SPAN = PREFIX_W;
	localparam int NUM_GROUPS = (SEARCH_OFFSETS + GROUP_SPAN - 1) / GROUP_SPAN;

	// request kinds
	localparam logic FUNC_DATA  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'b0;

	typedef logic [INDEX_BITS-1:0] index_t;

	// bitmap read request, one address per candidate group
	typedef struct packed {
		logic                       en;
		index_t [NUM_GROUPS-1:0]    addr;
	} cwd_rd_req_t;

	// bitmap write request
	typedef struct packed {
		logic   en;
		index_t addr;
		logic   data;
	} cwd_wr_req_t;

endpackage

// ===== src/cwd_if.sv =====
`timescale 1ns / 1ps

// request channel: received bytes and bitmap writes
interface cwd_item_if;
	import cwd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [BYTE_W-1:0]     data_byte;
	logic [INDEX_BITS-1:0] entry_index;
	logic                  entry_valid;

	modport source (output valid, func, data_byte, entry_index, entry_valid, input ready);
	modport sink (input valid, func, data_byte, entry_index, entry_valid, output ready);
endinterface

// result channel
interface cwd_result_if;
	import cwd_pkg::*;

	logic                valid;
	logic                ready;
	logic                found_valid;
	logic [CODE_W-1:0]   found_code;
	logic [OFFSET_W-1:0] found_offset;
	logic                target_hit;

	modport source (output valid, found_valid, found_code, found_offset, target_hit,
		input ready);
	modport sink (input valid, found_valid, found_code, found_offset, target_hit,
		output ready);
endinterface

// ===== src/codeword_window_detector_core.sv =====
`timescale 1ns / 1ps

// Sync word detector over a byte stream. Each request either shifts a byte into a
// 32-bit window or writes one entry of the 4096-entry codebook bitmap, and each
// request gives exactly one result. The block takes one request per cycle unless
// the bitmap sweep or a stalled result holds it back. A taken request passes
// through stage 1, alongside the registered read of the bitmap memory, and then the
// result register. The prefix 1110 cannot match at two shifts less than four
// apart, so the eight searched shifts need only two bitmap reads per byte. After
// reset the bitmap memory is cleared one entry a cycle: until the sweep ends no
// request is taken (item.ready stays low), while the target register can be
// written at any time.
module codeword_window_detector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	cwd_item_if.sink                       item,
	cwd_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cwd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cwd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cwd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cwd_pkg::*;

	logic [CODE_W-1:0]   target;
	logic                busy;
	logic                accept;
	logic                adv_s1;
	logic [WIN_W-1:0]    window_q;
	logic [WIN_W-1:0]    win_next;

	logic [NUM_GROUPS-1:0]                cand_hit;
	index_t [NUM_GROUPS-1:0]              cand_addr;
	logic [NUM_GROUPS-1:0][OFFSET_W-1:0]  cand_off;

	cwd_rd_req_t rd;
	cwd_wr_req_t wr;

	logic                                 valid_s1;
	logic                                 func_s1;
	logic [WIN_W-1:0]                     win_s1;
	logic [NUM_GROUPS-1:0]                cand_hit_s1;
	index_t [NUM_GROUPS-1:0]              cand_addr_s1;
	logic [NUM_GROUPS-1:0][OFFSET_W-1:0]  cand_off_s1;
	logic [NUM_GROUPS-1:0]                bit_s1;

	logic                found_valid;
	logic [CODE_W-1:0]   found_code;
	logic [OFFSET_W-1:0] found_offset;
	logic                target_hit;

	logic                valid_s2;
	logic                found_valid_s2;
	logic [CODE_W-1:0]   found_code_s2;
	logic [OFFSET_W-1:0] found_offset_s2;
	logic                target_hit_s2;

	cwd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.target  (target)
	);

	cwd_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.bit_s1 (bit_s1),
		.busy   (busy)
	);

	// flow control
	assign adv_s1     = !valid_s2 || result.ready;
	assign item.ready = !busy && (!valid_s1 || adv_s1);
	assign accept     = item.valid && item.ready;

	// window after the incoming byte
	assign win_next = {window_q[WIN_W-BYTE_W-1:0], item.data_byte};

	// prefix detect per shift, at most one candidate in each group
	always_comb begin
		cand_hit  = '0;
		cand_addr = '0;
		cand_off  = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			for (int j = 0; j < GROUP_SPAN; j++) begin
				if (g * GROUP_SPAN + j < SEARCH_OFFSETS) begin
					if (win_next[g * GROUP_SPAN + j + CODE_W - 1 -: PREFIX_W] == CODE_PREFIX) begin
						cand_hit[g]  = 1'b1;
						cand_addr[g] = cand_addr[g] |
							win_next[g * GROUP_SPAN + j + INDEX_BITS - 1 -: INDEX_BITS];
						cand_off[g]  = cand_off[g] | OFFSET_W'(g * GROUP_SPAN + j);
					end
				end
			end
		end
	end

	// bitmap requests
	always_comb begin
		rd.en   = accept && item.func == FUNC_DATA;
		rd.addr = cand_addr;
		wr.en   = accept && item.func == FUNC_WRITE;
		wr.addr = item.entry_index;
		wr.data = item.entry_valid;
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (accept && item.func == FUNC_DATA) begin
			window_q <= win_next;
		end
	end

	// stage 1: window and candidates, alongside the bitmap read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= item.func;
			win_s1       <= win_next;
			cand_hit_s1  <= cand_hit;
			cand_addr_s1 <= cand_addr;
			cand_off_s1  <= cand_off;
		end
	end

	// pick the highest marked candidate and search for the target
	always_comb begin
		found_valid  = 1'b0;
		found_code   = '0;
		found_offset = '0;
		target_hit   = 1'b0;
		if (func_s1 == FUNC_DATA) begin
			for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
				if (!found_valid && cand_hit_s1[g] && bit_s1[g]) begin
					found_valid  = 1'b1;
					found_code   = {CODE_PREFIX, cand_addr_s1[g]};
					found_offset = cand_off_s1[g];
				end
			end
			for (int s = 0; s < TARGET_SHIFTS; s++) begin
				if (win_s1[s + CODE_W - 1 -: CODE_W] == target) begin
					target_hit = 1'b1;
				end
			end
		end
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			found_valid_s2  <= found_valid;
			found_code_s2   <= found_code;
			found_offset_s2 <= found_offset;
			target_hit_s2   <= target_hit;
		end
	end

	assign result.valid        = valid_s2;
	assign result.found_valid  = found_valid_s2;
	assign result.found_code   = found_code_s2;
	assign result.found_offset = found_offset_s2;
	assign result.target_hit   = target_hit_s2;

	// a found codeword always carries the sync prefix
	a_found_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.found_valid |->
			result.found_code[CODE_W-1 -: PREFIX_W] == CODE_PREFIX)
		else $error("found codeword without prefix");

	// no codeword means zero code and offset
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found_valid |->
			result.found_code == '0 && result.found_offset == '0)
		else $error("empty result carries code or offset");

	// an accepted request always occupies stage 1 next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before stage 1");

	// a bitmap write leaves the window alone
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.func == FUNC_WRITE |=> $stable(window_q))
		else $error("bitmap write changed the window");

endmodule

// ===== src/cwd_apb_regs.sv =====
`timescale 1ns / 1ps

module cwd_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cwd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cwd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cwd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [cwd_pkg::CODE_W-1:0]     target
);
	import cwd_pkg::*;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [CODE_W-1:0]    target_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// target message register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (wr_en && reg_idx == REG_TARGET) begin
			target_q <= pwdata[CODE_W-1:0];
		end
	end

	// read decode
	always_comb begin
		unique case (reg_idx)
			REG_TARGET: prdata = APB_DATA_W'(target_q);
			default:    prdata = '0;
		endcase
	end

	assign target = target_q;

endmodule

// ===== src/cwd_bitmap.sv =====
`timescale 1ns / 1ps

module cwd_bitmap (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cwd_pkg::cwd_wr_req_t               wr,
	input  cwd_pkg::cwd_rd_req_t               rd,
	output logic [cwd_pkg::NUM_GROUPS-1:0]     bit_s1,
	output logic                               busy
);
	import cwd_pkg::*;

	logic               mem [BITMAP_DEPTH];
	logic               clearing_q;
	index_t             clr_addr_q;
	logic               we;
	index_t             waddr;
	logic               wdata;

	// clearing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == index_t'(BITMAP_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// write port shared by the sweep and bitmap write requests
	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = 1'b0;
		end else begin
			we    = wr.en;
			waddr = wr.addr;
			wdata = wr.data;
		end
	end

	// storage with one registered read per candidate group
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd.en) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				bit_s1[g] <= mem[rd.addr[g]];
			end
		end
	end

	assign busy = clearing_q;

endmodule
